// ===== hw/rtl/swrpm_pkg.sv =====
package swrpm_pkg;

    // Field widths
    localparam int CODE_W     = 16;
    localparam int INV_W      = 16;
    localparam int DROP_W     = 20;
    localparam int FLOOR_W    = 22;
    localparam int SWR_W      = 14;
    localparam int PWR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    // Internal widths
    localparam int RAW_W     = 22;              // up to 3300000 uV
    localparam int COMP_W    = 25;              // up to about 27.5e6 uV
    localparam int Y_W       = 31;              // code * 23250
    localparam int PROD_W    = RAW_W + INV_W;   // raw * Q3.13 gain
    localparam int Q13_SHIFT = 13;
    localparam int SQ_W      = 2 * COMP_W;
    localparam int S_W       = 37;              // square >> 9 when not saturated
    localparam int HM_W      = 45;              // (square >> 25) * reciprocal
    localparam int SWR_NUM_W = 33;              // 100 * (fc + rc)
    localparam int SWR_LIM_W = 39;              // 10000 * (fc - rc)

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DIV     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIODE_DROP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWR_WARN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POWER   = 3'd4;

    // Register reset values
    localparam logic [INV_W-1:0]   RST_INV_DIV     = 16'd8192;
    localparam logic [DROP_W-1:0]  RST_DIODE_DROP  = 20'd220000;
    localparam logic [FLOOR_W-1:0] RST_NOISE_FLOOR = 22'd50000;
    localparam logic [SWR_W-1:0]   RST_SWR_WARN    = 14'd300;
    localparam logic [PWR_W-1:0]   RST_MIN_POWER   = 16'd100;

    // code * 3300000 / 65535 = 50 * code + code * 23250 / 65535
    localparam logic [5:0]  RAW_INT_MUL  = 6'd50;
    localparam logic [14:0] RAW_FRAC_MUL = 15'd23250;

    // Power: uV^2 / 1e9, with 1e9 = 2^9 * 1953125
    localparam logic [SQ_W-1:0] PWR_SAT_SQ = 50'd65536000000000;
    localparam int              PWR_LO_SHIFT = 9;
    localparam int              PWR_HI_SHIFT = 25;
    localparam logic [20:0]     DIV_ODD      = 21'd1953125;
    localparam logic [23:0]     RECIP_M      = 24'd9007199;   // floor(2^44 / 1953125)
    localparam int              RECIP_SHIFT  = 28;
    localparam logic [PWR_W-1:0] PWR_CAP     = 16'd65535;

    // SWR
    localparam logic [6:0]       SWR_SCALE     = 7'd100;
    localparam logic [13:0]      SWR_LIMIT     = 14'd10000;
    localparam logic [SWR_W-1:0] SWR_CAP       = 14'd9999;
    localparam logic [SWR_W-1:0] SWR_NO_SIGNAL = 14'd100;

    // Pipeline latencies in register stages
    localparam int VOLT_LAT = 4;
    localparam int PWR_LAT  = 4;
    localparam int SWR_LAT  = 3 + SWR_W;

    typedef struct packed {
        logic [CODE_W-1:0] forward_code;
        logic [CODE_W-1:0] reflected_code;
    } sample_t;

    typedef struct packed {
        logic [SWR_W-1:0] swr_times_100;
        logic [PWR_W-1:0] forward_power_mw;
        logic [PWR_W-1:0] reflected_power_mw;
        logic             mismatch_alarm;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [INV_W-1:0]   inverse_divider_q13;
        logic [DROP_W-1:0]  diode_drop_uv;
        logic [FLOOR_W-1:0] noise_floor_uv;
        logic [SWR_W-1:0]   swr_warn_x100;
        logic [PWR_W-1:0]   alarm_min_power_mw;
    } cfg_t;

endpackage

// ===== hw/rtl/swrpm_stream_if.sv =====
interface swrpm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/swrpm_cfg_regs.sv =====
module swrpm_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    swrpm_stream_if.sink        wr,
    output swrpm_pkg::cfg_t     regs
);

    swrpm_pkg::cfg_t cfg_reg;
    swrpm_pkg::cfg_t cfg_next;

    assign wr.ready = 1'b1;
    assign regs     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr.valid)
        begin
            unique case (wr.payload.index)
                swrpm_pkg::CFG_INV_DIV:
                    cfg_next.inverse_divider_q13 = wr.payload.data[swrpm_pkg::INV_W-1:0];
                swrpm_pkg::CFG_DIODE_DROP:
                    cfg_next.diode_drop_uv = wr.payload.data[swrpm_pkg::DROP_W-1:0];
                swrpm_pkg::CFG_NOISE_FLOOR:
                    cfg_next.noise_floor_uv = wr.payload.data[swrpm_pkg::FLOOR_W-1:0];
                swrpm_pkg::CFG_SWR_WARN:
                    cfg_next.swr_warn_x100 = wr.payload.data[swrpm_pkg::SWR_W-1:0];
                swrpm_pkg::CFG_MIN_POWER:
                    cfg_next.alarm_min_power_mw = wr.payload.data[swrpm_pkg::PWR_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inverse_divider_q13 <= swrpm_pkg::RST_INV_DIV;
            cfg_reg.diode_drop_uv       <= swrpm_pkg::RST_DIODE_DROP;
            cfg_reg.noise_floor_uv      <= swrpm_pkg::RST_NOISE_FLOOR;
            cfg_reg.swr_warn_x100       <= swrpm_pkg::RST_SWR_WARN;
            cfg_reg.alarm_min_power_mw  <= swrpm_pkg::RST_MIN_POWER;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/swrpm_volt.sv =====
module swrpm_volt (
    input  logic                                clk,
    input  logic                                en,
    input  logic [swrpm_pkg::CODE_W-1:0]        code,
    input  swrpm_pkg::cfg_t                     regs,
    output logic [swrpm_pkg::COMP_W-1:0]        comp,
    output logic                                above
);

    localparam int CDW = swrpm_pkg::CODE_W;
    localparam int YW  = swrpm_pkg::Y_W;
    localparam int RW  = swrpm_pkg::RAW_W;
    localparam int PW  = swrpm_pkg::PROD_W;
    localparam int CW  = swrpm_pkg::COMP_W;
    localparam int SH  = swrpm_pkg::Q13_SHIFT;

    logic [YW-1:0]  y_reg,    y_next;
    logic [CDW-1:0] code_reg;
    logic [RW-1:0]  raw_reg,  raw_next;
    logic [PW-1:0]  prod_reg, prod_next;
    logic           above3_reg, above3_next;
    logic [CW-1:0]  comp_reg, comp_next;
    logic           above4_reg;
    logic [YW:0]    qsum;

    assign y_next = YW'(code) * YW'(swrpm_pkg::RAW_FRAC_MUL);

    // floor(y / 65535) = (y + (y >> 16) + 1) >> 16 for the range of y here.
    assign qsum     = {1'b0, y_reg} + (YW+1)'(y_reg[YW-1:16]) + (YW+1)'(1);
    assign raw_next = RW'(code_reg) * RW'(swrpm_pkg::RAW_INT_MUL) + RW'(qsum[YW:16]);

    assign prod_next   = PW'(raw_reg) * PW'(regs.inverse_divider_q13);
    assign above3_next = raw_reg >= regs.noise_floor_uv;

    assign comp_next = CW'(prod_reg[PW-1:SH]) + CW'(regs.diode_drop_uv);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg      <= y_next;
            code_reg   <= code;
            raw_reg    <= raw_next;
            prod_reg   <= prod_next;
            above3_reg <= above3_next;
            comp_reg   <= comp_next;
            above4_reg <= above3_reg;
        end
    end

    assign comp  = comp_reg;
    assign above = above4_reg;

endmodule

// ===== hw/rtl/swrpm_power.sv =====
module swrpm_power (
    input  logic                            clk,
    input  logic                            en,
    input  logic [swrpm_pkg::COMP_W-1:0]    comp,
    input  logic                            above,
    output logic [swrpm_pkg::PWR_W-1:0]     power
);

    localparam int CW  = swrpm_pkg::COMP_W;
    localparam int QW  = swrpm_pkg::SQ_W;
    localparam int SW  = swrpm_pkg::S_W;
    localparam int HW  = swrpm_pkg::HM_W;
    localparam int PW  = swrpm_pkg::PWR_W;
    localparam int LO  = swrpm_pkg::PWR_LO_SHIFT;
    localparam int HI  = swrpm_pkg::PWR_HI_SHIFT;
    localparam int RS  = swrpm_pkg::RECIP_SHIFT;

    logic [QW-1:0] sq_reg, sq_next;
    logic          ab1_reg;
    logic [SW-1:0] s2_reg;
    logic [HW-1:0] hm_reg, hm_next;
    logic          sat2_reg, sat2_next;
    logic          ab2_reg;
    logic [PW-1:0] qe_reg;
    logic [SW-1:0] qd_reg, qd_next;
    logic [SW-1:0] s3_reg;
    logic          sat3_reg;
    logic          ab3_reg;
    logic [PW-1:0] pwr_reg, pwr_next;
    logic [SW-1:0] rem;
    logic [PW-1:0] quo;

    assign sq_next = QW'(comp) * QW'(comp);

    // Estimate of floor(s / 1953125) from the upper bits of s; it is low by at most one.
    assign sat2_next = sq_reg >= swrpm_pkg::PWR_SAT_SQ;
    assign hm_next   = HW'(sq_reg[LO+SW-1:HI]) * HW'(swrpm_pkg::RECIP_M);

    assign qd_next = SW'(hm_reg[RS+PW-1:RS]) * SW'(swrpm_pkg::DIV_ODD);

    assign rem = s3_reg - qd_reg;
    assign quo = qe_reg + PW'(rem >= SW'(swrpm_pkg::DIV_ODD));

    always_comb
    begin
        priority if (!ab3_reg)
            pwr_next = '0;
        else if (sat3_reg)
            pwr_next = swrpm_pkg::PWR_CAP;
        else
            pwr_next = quo;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg   <= sq_next;
            ab1_reg  <= above;
            s2_reg   <= sq_reg[LO+SW-1:LO];
            hm_reg   <= hm_next;
            sat2_reg <= sat2_next;
            ab2_reg  <= ab1_reg;
            qe_reg   <= hm_reg[RS+PW-1:RS];
            qd_reg   <= qd_next;
            s3_reg   <= s2_reg;
            sat3_reg <= sat2_reg;
            ab3_reg  <= ab2_reg;
            pwr_reg  <= pwr_next;
        end
    end

    assign power = pwr_reg;

endmodule

// ===== hw/rtl/swrpm_swr.sv =====
module swrpm_swr (
    input  logic                            clk,
    input  logic                            en,
    input  logic [swrpm_pkg::COMP_W-1:0]    fc,
    input  logic [swrpm_pkg::COMP_W-1:0]    rc,
    input  logic                            fabove,
    output logic [swrpm_pkg::SWR_W-1:0]     swr
);

    localparam int CW = swrpm_pkg::COMP_W;
    localparam int NW = swrpm_pkg::SWR_NUM_W;
    localparam int LW = swrpm_pkg::SWR_LIM_W;
    localparam int QW = swrpm_pkg::SWR_W;

    logic [NW-1:0] num1_reg, num1_next;
    logic [CW-1:0] den1_reg, den1_next;
    logic          open1_reg, open1_next;
    logic          ab1_reg;
    logic [NW-1:0] num2_reg;
    logic [CW-1:0] den2_reg;
    logic [LW-1:0] lim2_reg, lim2_next;
    logic          open2_reg;
    logic          ab2_reg;

    // One quotient bit per stage, most significant first.
    logic [NW-1:0] rem_reg [QW+1];
    logic [CW-1:0] dv_reg  [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic          sat_reg [QW+1];
    logic          ab_reg  [QW+1];

    logic [NW-1:0] rem_next [QW];
    logic [QW-1:0] q_next   [QW];
    logic [LW-1:0] dsh      [QW];
    logic          take     [QW];
    logic          sat0_next;

    assign num1_next  = NW'({1'b0, fc} + {1'b0, rc}) * NW'(swrpm_pkg::SWR_SCALE);
    assign den1_next  = fc - rc;
    assign open1_next = rc >= fc;

    assign lim2_next = LW'(den1_reg) * LW'(swrpm_pkg::SWR_LIMIT);

    // A quotient of 10000 or more, or reflected at or above forward, reads as the cap.
    assign sat0_next = open2_reg || (LW'(num2_reg) >= lim2_reg);

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            dsh[k]      = LW'(dv_reg[k]) << (QW - 1 - k);
            take[k]     = LW'(rem_reg[k]) >= dsh[k];
            rem_next[k] = take[k] ? NW'(LW'(rem_reg[k]) - dsh[k]) : rem_reg[k];
            q_next[k]   = q_reg[k] | (QW'(take[k]) << (QW - 1 - k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg   <= num1_next;
            den1_reg   <= den1_next;
            open1_reg  <= open1_next;
            ab1_reg    <= fabove;
            num2_reg   <= num1_reg;
            den2_reg   <= den1_reg;
            lim2_reg   <= lim2_next;
            open2_reg  <= open1_reg;
            ab2_reg    <= ab1_reg;
            rem_reg[0] <= num2_reg;
            dv_reg[0]  <= den2_reg;
            q_reg[0]   <= '0;
            sat_reg[0] <= sat0_next;
            ab_reg[0]  <= ab2_reg;
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k+1] <= rem_next[k];
                dv_reg[k+1]  <= dv_reg[k];
                q_reg[k+1]   <= q_next[k];
                sat_reg[k+1] <= sat_reg[k];
                ab_reg[k+1]  <= ab_reg[k];
            end
        end
    end

    always_comb
    begin
        priority if (!ab_reg[QW])
            swr = swrpm_pkg::SWR_NO_SIGNAL;
        else if (sat_reg[QW])
            swr = swrpm_pkg::SWR_CAP;
        else
            swr = q_reg[QW];
    end

endmodule

// ===== hw/rtl/swr_and_rf_power_meter_unit.sv =====
// Channel  Direction  Word                                        Handshake
// cfg      in         index, data (register write)                valid/ready, ready always high
// sample   in         forward_code, reflected_code                valid/ready
// result   out        swr_times_100, power in mW, mismatch_alarm  valid/ready
//
// One sample word is taken per clock while the pipeline is not stalled by the result channel.
// The longest path is the 14-stage restoring divider for SWR, which sits behind 7 stages
// of voltage scaling and sum/difference scaling and ahead of the output register.
// Reset clears the valid bits and loads the register defaults; data stages are not reset.
// A stalled result holds the whole pipeline, so sample.ready drops only while a finished
// result waits at the output and the last stage is full.

module swr_and_rf_power_meter_unit (
    input  logic            clk,
    input  logic            rst_n,
    swrpm_stream_if.sink    cfg,
    swrpm_stream_if.sink    sample,
    swrpm_stream_if.source  result
);

    localparam int CW      = swrpm_pkg::COMP_W;
    localparam int PW      = swrpm_pkg::PWR_W;
    localparam int SWW     = swrpm_pkg::SWR_W;
    localparam int OUT_LAT = swrpm_pkg::VOLT_LAT + swrpm_pkg::SWR_LAT + 1;
    localparam int PDLY    = swrpm_pkg::SWR_LAT - swrpm_pkg::PWR_LAT;

    swrpm_pkg::cfg_t    regs;
    logic               en;
    logic               vld_reg [OUT_LAT];

    logic [CW-1:0]      fc;
    logic [CW-1:0]      rc;
    logic               fabove;
    logic               rabove;
    logic [PW-1:0]      fpwr;
    logic [PW-1:0]      rpwr;
    logic [SWW-1:0]     swr;
    logic [PW-1:0]      fpd_reg [PDLY];
    logic [PW-1:0]      rpd_reg [PDLY];

    swrpm_pkg::result_t res_reg;
    swrpm_pkg::result_t res_next;

    assign en           = !vld_reg[OUT_LAT-1] || result.ready;
    assign sample.ready = en;

    swrpm_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cfg),
        .regs  (regs)
    );

    swrpm_volt u_volt_fwd (
        .clk   (clk),
        .en    (en),
        .code  (sample.payload.forward_code),
        .regs  (regs),
        .comp  (fc),
        .above (fabove)
    );

    swrpm_volt u_volt_rfl (
        .clk   (clk),
        .en    (en),
        .code  (sample.payload.reflected_code),
        .regs  (regs),
        .comp  (rc),
        .above (rabove)
    );

    swrpm_power u_pwr_fwd (
        .clk   (clk),
        .en    (en),
        .comp  (fc),
        .above (fabove),
        .power (fpwr)
    );

    swrpm_power u_pwr_rfl (
        .clk   (clk),
        .en    (en),
        .comp  (rc),
        .above (rabove),
        .power (rpwr)
    );

    swrpm_swr u_swr (
        .clk    (clk),
        .en     (en),
        .fc     (fc),
        .rc     (rc),
        .fabove (fabove),
        .swr    (swr)
    );

    always_comb
    begin
        res_next.swr_times_100      = swr;
        res_next.forward_power_mw   = fpd_reg[PDLY-1];
        res_next.reflected_power_mw = rpd_reg[PDLY-1];
        res_next.mismatch_alarm     = (swr > regs.swr_warn_x100)
                                      && (fpd_reg[PDLY-1] > regs.alarm_min_power_mw);
    end

    // Power words wait here until the SWR of the same sample comes out of the divider.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fpd_reg[0] <= fpwr;
            rpd_reg[0] <= rpwr;
            for (int k = 1; k < PDLY; k++)
            begin
                fpd_reg[k] <= fpd_reg[k-1];
                rpd_reg[k] <= rpd_reg[k-1];
            end
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < OUT_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= sample.valid;
            for (int k = 1; k < OUT_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign result.valid   = vld_reg[OUT_LAT-1];
    assign result.payload = res_reg;

endmodule
